FILE: design/pas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-and-shoot sequencer package
// Phase, command, mode and register codes, the sequencer state type and the
// CORDIC arctangent table shared by the sequencer modules.
// ----------------------------------------------------------------------------
package pas_pkg;

    localparam int TAB_LEN = 24;
    localparam int TAB_IDX_W = $clog2(TAB_LEN);

    localparam logic [3:0] PH_IDLE        = 4'd0;
    localparam logic [3:0] PH_START_ROT   = 4'd1;
    localparam logic [3:0] PH_ROT         = 4'd2;
    localparam logic [3:0] PH_START_MOVE  = 4'd3;
    localparam logic [3:0] PH_MOVE        = 4'd4;
    localparam logic [3:0] PH_SMOOTH      = 4'd5;
    localparam logic [3:0] PH_START_ROT_T = 4'd6;
    localparam logic [3:0] PH_ROT_T       = 4'd7;
    localparam logic [3:0] PH_STOP        = 4'd8;

    localparam logic [2:0] CMD_NONE = 3'd0;
    localparam logic [2:0] CMD_MOVE = 3'd1;
    localparam logic [2:0] CMD_CCW  = 3'd2;
    localparam logic [2:0] CMD_CW   = 3'd3;
    localparam logic [2:0] CMD_STOP = 3'd4;

    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_HEAD   = 3'd1;
    localparam logic [2:0] MODE_SMOOTH = 3'd2;
    localparam logic [2:0] MODE_TARGET = 3'd3;
    localparam logic [2:0] MODE_STOP   = 3'd4;
    localparam logic [2:0] MODE_SPEED  = 3'd5;

    localparam logic [1:0] AM_INF    = 2'd0;
    localparam logic [1:0] AM_SMOOTH = 2'd1;
    localparam logic [1:0] AM_TARGET = 2'd2;

    localparam logic [2:0] REG_HEADING_TOL     = 3'd0;
    localparam logic [2:0] REG_DIST_TOL        = 3'd1;
    localparam logic [2:0] REG_CURVE_GAIN      = 3'd2;
    localparam logic [2:0] REG_SMOOTH_GAIN     = 3'd3;
    localparam logic [2:0] REG_SMOOTH_DEADBAND = 3'd4;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_DISP = 8'b0000_0010,
        S_CORD = 8'b0000_0100,
        S_POST = 8'b0000_1000,
        S_MUL  = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_FIN  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    // Arctangent of 2^-i, with a full turn equal to 2^32.
    function automatic logic [31:0] atan_entry(input logic [TAB_IDX_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051D;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2E;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2F9;
            5'd15:   v = 32'h0000517C;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A2F;
            5'd19:   v = 32'h00000517;
            5'd20:   v = 32'h0000028B;
            5'd21:   v = 32'h00000145;
            5'd22:   v = 32'h000000A2;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

FILE: design/point_and_shoot_motion_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-and-shoot motion sequencer
// Differential-drive sequencer that turns ticks and commands into drive
// commands, with an iterative CORDIC, a serial divider and a shared multiplier.
// ----------------------------------------------------------------------------
// Each accepted item yields exactly one drive result, and the block takes no
// new item until that result has been transferred. Stop, speed and plain
// ticks go from dispatch straight to the finish state; a distance check in
// target mode first runs its products on the shared multiplier; heading
// commands run the CORDIC and a post state, and in smooth mode may add the
// smoothing product; a curving tick waits on the serial divider.
module point_and_shoot_motion_sequencer import pas_pkg::*;
#(
    parameter int POS_BITS     = 24,
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16,
    parameter int MAX_RADIUS   = 1000000
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_index,
    input  logic [31:0]                   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0]                    mode,
    input  logic signed [POS_BITS-1:0]    pose_x,
    input  logic signed [POS_BITS-1:0]    pose_y,
    input  logic signed [ANGLE_BITS-1:0]  pose_heading,
    input  logic signed [15:0]            dir_x,
    input  logic signed [15:0]            dir_y,
    input  logic signed [POS_BITS-1:0]    goal_x,
    input  logic signed [POS_BITS-1:0]    goal_y,
    input  logic signed [ANGLE_BITS-1:0]  goal_heading,
    input  logic [15:0]                   new_speed,
    input  logic                          speed_valid,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    drive_cmd,
    output logic [15:0]                   drive_speed,
    output logic signed [20:0]            drive_radius,
    output logic [3:0]                    phase_out,
    output logic [1:0]                    mode_out
);

    localparam int DW   = POS_BITS + 1;
    localparam int MW   = (DW > ANGLE_BITS + 1) ? DW : ANGLE_BITS + 1;
    localparam int PW   = 2 * MW;
    localparam int SW   = PW + 2;
    localparam int CMPW = ANGLE_BITS + 16;
    localparam int RW   = 33;

    state_t state_reg, state_next;

    logic [14:0] heading_tol_reg;
    logic [15:0] dist_tol_reg;
    logic [31:0] curve_gain_reg;
    logic [16:0] smooth_gain_reg;
    logic [14:0] smooth_deadband_reg;

    logic [2:0]                   imode_reg;
    logic [POS_BITS-1:0]          px_reg, py_reg, gx_reg, gy_reg;
    logic [ANGLE_BITS-1:0]        ph_reg, gh_reg;
    logic [15:0]                  vx_reg, vy_reg, nspd_reg;
    logic                         spv_reg;

    logic [1:0]             step_reg;
    logic [ANGLE_BITS-1:0]  ang_reg;
    logic [31:0]            quot_reg;
    logic [PW-1:0]          sqa_reg, sqb_reg, prod_reg;

    logic [3:0]             phase_reg, phase_next;
    logic [1:0]             am_reg, am_next;
    logic [ANGLE_BITS-1:0]  want_reg, want_next;
    logic [ANGLE_BITS-1:0]  filt_reg, filt_next;
    logic [POS_BITS-1:0]    aim_x_reg, aim_x_next, aim_y_reg, aim_y_next;
    logic [ANGLE_BITS-1:0]  aim_h_reg, aim_h_next;
    logic [POS_BITS-1:0]    org_x_reg, org_x_next, org_y_reg, org_y_next;
    logic [63:0]            trip_reg, trip_next;
    logic [15:0]            speed_reg, speed_next;
    logic                   turn_reg, turn_next;

    logic [2:0]             cmd_reg, cmd_next;
    logic [15:0]            dspd_reg, dspd_next;
    logic [20:0]            rad_reg;
    logic signed [RW-1:0]   rad_next;

    logic [ANGLE_BITS-1:0]        hsel;
    logic signed [ANGLE_BITS-1:0] err;
    logic [ANGLE_BITS-1:0]        err_mag;
    logic                         in_tol;
    logic signed [DW-1:0]         ddx, ddy;
    logic [DW-1:0]                mag_dx, mag_dy;
    logic signed [DW-1:0]         cx, cy;
    logic signed [ANGLE_BITS-1:0] sd;
    logic [ANGLE_BITS-1:0]        sd_mag;
    logic                         smooth_move;
    logic signed [ANGLE_BITS-1:0] he;
    logic [ANGLE_BITS-1:0]        he_mag;
    logic [MW-1:0]                mul_a, mul_b;
    logic [PW-1:0]                product;
    logic [65:0]                  dsum;
    logic [63:0]                  d2;
    logic signed [SW-1:0]         sprod, sval, sstep;
    logic [31:0]                  q_sat;
    logic                         tick, need_div, need_dist, need_cord;
    logic                         cord_start, cord_done, div_start, div_done;
    logic [ANGLE_BITS-1:0]        cord_angle;
    logic [31:0]                  div_quot;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        hsel    = (phase_reg == PH_START_ROT_T || phase_reg == PH_ROT_T) ? aim_h_reg : want_reg;
        err     = signed'(hsel - ph_reg);
        err_mag = err[ANGLE_BITS-1] ? ANGLE_BITS'(-err) : ANGLE_BITS'(err);
        in_tol  = (CMPW'(err_mag) < CMPW'(heading_tol_reg));

        if (phase_reg == PH_START_MOVE)
        begin
            ddx = $signed({aim_x_reg[POS_BITS-1], aim_x_reg}) - $signed({px_reg[POS_BITS-1], px_reg});
            ddy = $signed({aim_y_reg[POS_BITS-1], aim_y_reg}) - $signed({py_reg[POS_BITS-1], py_reg});
        end
        else
        begin
            ddx = $signed({px_reg[POS_BITS-1], px_reg}) - $signed({org_x_reg[POS_BITS-1], org_x_reg});
            ddy = $signed({py_reg[POS_BITS-1], py_reg}) - $signed({org_y_reg[POS_BITS-1], org_y_reg});
        end
        mag_dx = ddx[DW-1] ? DW'(-ddx) : DW'(ddx);
        mag_dy = ddy[DW-1] ? DW'(-ddy) : DW'(ddy);

        if (imode_reg == MODE_TARGET)
        begin
            cx = $signed({gx_reg[POS_BITS-1], gx_reg}) - $signed({px_reg[POS_BITS-1], px_reg});
            cy = $signed({gy_reg[POS_BITS-1], gy_reg}) - $signed({py_reg[POS_BITS-1], py_reg});
        end
        else
        begin
            cx = $signed({{(DW-16){vx_reg[15]}}, vx_reg});
            cy = $signed({{(DW-16){vy_reg[15]}}, vy_reg});
        end

        sd          = signed'(ang_reg - filt_reg);
        sd_mag      = sd[ANGLE_BITS-1] ? ANGLE_BITS'(-sd) : ANGLE_BITS'(sd);
        smooth_move = (CMPW'(sd_mag) > CMPW'(smooth_deadband_reg));
        he          = signed'(ang_reg - want_reg);
        he_mag      = he[ANGLE_BITS-1] ? ANGLE_BITS'(-he) : ANGLE_BITS'(he);

        case (step_reg)
            2'd0:
            begin
                mul_a = MW'(mag_dx);
                mul_b = MW'(mag_dx);
            end
            2'd1:
            begin
                mul_a = MW'(mag_dy);
                mul_b = MW'(mag_dy);
            end
            2'd2:
            begin
                mul_a = MW'(dist_tol_reg);
                mul_b = MW'(dist_tol_reg);
            end
            default:
            begin
                mul_a = MW'(sd_mag);
                mul_b = MW'(smooth_gain_reg);
            end
        endcase
        product = PW'(mul_a) * PW'(mul_b);

        dsum = 66'(sqa_reg) + 66'(sqb_reg);
        d2   = (dsum[65:64] != 2'b00) ? 64'hFFFF_FFFF_FFFF_FFFF : dsum[63:0];

        sprod = $signed({2'b00, prod_reg});
        sval  = (sd[ANGLE_BITS-1] ? -sprod : sprod) + SW'(32768);
        sstep = sval >>> 16;

        q_sat = (quot_reg > 32'(MAX_RADIUS)) ? 32'(MAX_RADIUS) : quot_reg;

        tick      = (imode_reg == MODE_TICK);
        need_div  = tick && (phase_reg == PH_SMOOTH) && !in_tol && (err_mag != '0);
        need_dist = tick && (am_reg == AM_TARGET) &&
                    (phase_reg == PH_START_MOVE || phase_reg == PH_MOVE);
        need_cord = (imode_reg == MODE_HEAD || imode_reg == MODE_SMOOTH ||
                     imode_reg == MODE_TARGET);
    end

    assign cord_start = (state_reg == S_DISP) && need_cord && !need_dist && !need_div;
    assign div_start  = (state_reg == S_DISP) && need_div;

    pas_cordic #(
        .IN_W       (DW),
        .ANGLE_BITS (ANGLE_BITS),
        .STEPS      (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cord_start),
        .x_in  (cx),
        .y_in  (cy),
        .done  (cord_done),
        .angle (cord_angle)
    );

    pas_div #(
        .DIVISOR_W (ANGLE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (curve_gain_reg),
        .divisor  (err_mag),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (need_div)
                begin
                    state_next = S_DIV;
                end
                else if (need_dist)
                begin
                    state_next = S_MUL;
                end
                else if (need_cord)
                begin
                    state_next = S_CORD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_CORD:
            begin
                if (cord_done)
                begin
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                state_next = (imode_reg == MODE_SMOOTH && smooth_move) ? S_MUL : S_FIN;
            end
            S_MUL:
            begin
                if (step_reg == 2'd2 || step_reg == 2'd3)
                begin
                    state_next = S_FIN;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        am_next    = am_reg;
        want_next  = want_reg;
        filt_next  = filt_reg;
        aim_x_next = aim_x_reg;
        aim_y_next = aim_y_reg;
        aim_h_next = aim_h_reg;
        org_x_next = org_x_reg;
        org_y_next = org_y_reg;
        trip_next  = trip_reg;
        speed_next = speed_reg;
        turn_next  = turn_reg;
        cmd_next   = CMD_NONE;
        rad_next   = '0;

        case (imode_reg)
            MODE_TICK:
            begin
                case (phase_reg)
                    PH_START_ROT, PH_START_ROT_T:
                    begin
                        if (in_tol)
                        begin
                            phase_next = (phase_reg == PH_START_ROT) ? PH_START_MOVE : PH_STOP;
                        end
                        else
                        begin
                            phase_next = (phase_reg == PH_START_ROT) ? PH_ROT : PH_ROT_T;
                            turn_next  = (err > 0);
                            cmd_next   = (err > 0) ? CMD_CCW : CMD_CW;
                        end
                    end
                    PH_ROT, PH_ROT_T:
                    begin
                        if (in_tol || (turn_reg && err < 0) || (!turn_reg && err > 0))
                        begin
                            phase_next = (phase_reg == PH_ROT) ? PH_START_MOVE : PH_STOP;
                        end
                    end
                    PH_START_MOVE:
                    begin
                        if (am_reg == AM_TARGET)
                        begin
                            if (d2 < 64'(prod_reg[31:0]))
                            begin
                                phase_next = PH_START_ROT_T;
                            end
                            else
                            begin
                                org_x_next = px_reg;
                                org_y_next = py_reg;
                                trip_next  = d2;
                                cmd_next   = CMD_MOVE;
                                rad_next   = RW'(MAX_RADIUS);
                                phase_next = PH_MOVE;
                            end
                        end
                        else if (am_reg == AM_INF)
                        begin
                            cmd_next   = CMD_MOVE;
                            rad_next   = RW'(MAX_RADIUS);
                            phase_next = PH_MOVE;
                        end
                    end
                    PH_MOVE:
                    begin
                        if (am_reg == AM_TARGET && d2 >= trip_reg)
                        begin
                            phase_next = PH_START_ROT_T;
                        end
                    end
                    PH_SMOOTH:
                    begin
                        if (in_tol)
                        begin
                            phase_next = PH_START_MOVE;
                        end
                        else
                        begin
                            cmd_next = CMD_MOVE;
                            if (err_mag == '0)
                            begin
                                rad_next = RW'(MAX_RADIUS);
                            end
                            else if (err < 0)
                            begin
                                rad_next = -$signed({1'b0, q_sat});
                            end
                            else
                            begin
                                rad_next = $signed({1'b0, q_sat});
                            end
                        end
                    end
                    PH_STOP:
                    begin
                        cmd_next   = CMD_STOP;
                        phase_next = PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
            MODE_HEAD:
            begin
                am_next = AM_INF;
                if (CMPW'(he_mag) > CMPW'(heading_tol_reg) ||
                    phase_reg == PH_IDLE || phase_reg == PH_STOP)
                begin
                    want_next  = ang_reg;
                    phase_next = PH_START_ROT;
                end
                if (spv_reg)
                begin
                    speed_next = nspd_reg;
                end
            end
            MODE_SMOOTH:
            begin
                am_next = AM_SMOOTH;
                if (smooth_move)
                begin
                    filt_next = filt_reg + sstep[ANGLE_BITS-1:0];
                end
                want_next = filt_next;
                if (spv_reg)
                begin
                    speed_next = nspd_reg;
                end
                phase_next = PH_SMOOTH;
                cmd_next   = CMD_MOVE;
                rad_next   = RW'(MAX_RADIUS);
            end
            MODE_TARGET:
            begin
                am_next    = AM_TARGET;
                aim_x_next = gx_reg;
                aim_y_next = gy_reg;
                aim_h_next = gh_reg;
                want_next  = ang_reg;
                if (spv_reg)
                begin
                    speed_next = nspd_reg;
                end
                phase_next = PH_START_ROT;
            end
            MODE_STOP:
            begin
                cmd_next   = CMD_STOP;
                phase_next = PH_IDLE;
            end
            MODE_SPEED:
            begin
                if (spv_reg)
                begin
                    speed_next = nspd_reg;
                end
            end
            default:
            begin
                cmd_next = CMD_NONE;
            end
        endcase

        dspd_next = (cmd_next == CMD_MOVE || cmd_next == CMD_CCW || cmd_next == CMD_CW) ?
                    speed_next : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            heading_tol_reg     <= 15'd182;
            dist_tol_reg        <= 16'd10;
            curve_gain_reg      <= 32'd65536000;
            smooth_gain_reg     <= 17'd16384;
            smooth_deadband_reg <= 15'd182;
            step_reg            <= 2'd0;
            phase_reg           <= PH_IDLE;
            am_reg              <= AM_INF;
            want_reg            <= '0;
            filt_reg            <= '0;
            aim_x_reg           <= '0;
            aim_y_reg           <= '0;
            aim_h_reg           <= '0;
            org_x_reg           <= '0;
            org_y_reg           <= '0;
            trip_reg            <= '0;
            speed_reg           <= '0;
            turn_reg            <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_HEADING_TOL:     heading_tol_reg     <= cfg_data[14:0];
                    REG_DIST_TOL:        dist_tol_reg        <= cfg_data[15:0];
                    REG_CURVE_GAIN:      curve_gain_reg      <= cfg_data;
                    REG_SMOOTH_GAIN:     smooth_gain_reg     <= cfg_data[16:0];
                    REG_SMOOTH_DEADBAND: smooth_deadband_reg <= cfg_data[14:0];
                    default:             heading_tol_reg     <= heading_tol_reg;
                endcase
            end

            if (state_reg == S_DISP)
            begin
                step_reg <= 2'd0;
            end
            else if (state_reg == S_POST)
            begin
                step_reg <= 2'd3;
            end
            else if (state_reg == S_MUL)
            begin
                step_reg <= step_reg + 2'd1;
            end

            if (state_reg == S_FIN)
            begin
                phase_reg <= phase_next;
                am_reg    <= am_next;
                want_reg  <= want_next;
                filt_reg  <= filt_next;
                aim_x_reg <= aim_x_next;
                aim_y_reg <= aim_y_next;
                aim_h_reg <= aim_h_next;
                org_x_reg <= org_x_next;
                org_y_reg <= org_y_next;
                trip_reg  <= trip_next;
                speed_reg <= speed_next;
                turn_reg  <= turn_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            imode_reg <= mode;
            px_reg    <= pose_x;
            py_reg    <= pose_y;
            ph_reg    <= pose_heading;
            vx_reg    <= dir_x;
            vy_reg    <= dir_y;
            gx_reg    <= goal_x;
            gy_reg    <= goal_y;
            gh_reg    <= goal_heading;
            nspd_reg  <= new_speed;
            spv_reg   <= speed_valid;
        end
        if (cord_done)
        begin
            ang_reg <= cord_angle;
        end
        if (div_done)
        begin
            quot_reg <= div_quot;
        end
        if (state_reg == S_MUL)
        begin
            case (step_reg)
                2'd0:    sqa_reg  <= product;
                2'd1:    sqb_reg  <= product;
                default: prod_reg <= product;
            endcase
        end
        if (state_reg == S_FIN)
        begin
            cmd_reg  <= cmd_next;
            dspd_reg <= dspd_next;
            rad_reg  <= rad_next[20:0];
        end
    end

    assign drive_cmd    = cmd_reg;
    assign drive_speed  = dspd_reg;
    assign drive_radius = rad_reg;
    assign phase_out    = phase_reg;
    assign mode_out     = am_reg;

endmodule

FILE: design/pas_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative CORDIC arctangent
// Vectoring CORDIC that turns a signed vector into a binary angle, one
// micro-rotation per clock, rounded to the nearest angle unit.
// ----------------------------------------------------------------------------
module pas_cordic import pas_pkg::*;
#(
    parameter int IN_W       = 25,
    parameter int ANGLE_BITS = 16,
    parameter int STEPS      = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [IN_W-1:0]  x_in,
    input  logic signed [IN_W-1:0]  y_in,
    output logic                    done,
    output logic [ANGLE_BITS-1:0]   angle
);

    localparam int CW = IN_W + 23;

    logic signed [CW-1:0]   x_reg;
    logic signed [CW-1:0]   y_reg;
    logic [31:0]            acc_reg;
    logic [TAB_IDX_W-1:0]   idx_reg;
    logic                   run_reg;
    logic                   done_reg;
    logic [ANGLE_BITS-1:0]  angle_reg;

    logic signed [CW-1:0]   x_ld;
    logic signed [CW-1:0]   y_ld;
    logic signed [CW-1:0]   x_sh;
    logic signed [CW-1:0]   y_sh;
    logic signed [CW-1:0]   x_next;
    logic signed [CW-1:0]   y_next;
    logic [31:0]            acc_next;
    logic [31:0]            acc_rnd;
    logic                   last;

    always_comb
    begin
        x_ld = CW'(x_in) <<< 20;
        y_ld = CW'(y_in) <<< 20;
        x_sh = x_reg >>> idx_reg;
        y_sh = y_reg >>> idx_reg;
        if (y_reg > 0)
        begin
            x_next   = x_reg + y_sh;
            y_next   = y_reg - x_sh;
            acc_next = acc_reg + atan_entry(idx_reg);
        end
        else
        begin
            x_next   = x_reg - y_sh;
            y_next   = y_reg + x_sh;
            acc_next = acc_reg - atan_entry(idx_reg);
        end
        acc_rnd = acc_next + (32'd1 << (31 - ANGLE_BITS));
        last    = (idx_reg == TAB_IDX_W'(STEPS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (x_in == '0 && y_in == '0)
                begin
                    done_reg  <= 1'b1;
                    angle_reg <= '0;
                end
                else
                begin
                    run_reg <= 1'b1;
                    idx_reg <= '0;
                    if (x_in < 0)
                    begin
                        x_reg   <= -x_ld;
                        y_reg   <= -y_ld;
                        acc_reg <= 32'h80000000;
                    end
                    else
                    begin
                        x_reg   <= x_ld;
                        y_reg   <= y_ld;
                        acc_reg <= 32'h0;
                    end
                end
            end
            else if (run_reg)
            begin
                x_reg   <= x_next;
                y_reg   <= y_next;
                acc_reg <= acc_next;
                idx_reg <= idx_reg + 1'b1;
                if (last)
                begin
                    run_reg   <= 1'b0;
                    done_reg  <= 1'b1;
                    angle_reg <= acc_rnd[31 -: ANGLE_BITS];
                end
            end
        end
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule

FILE: design/pas_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned 32-bit by narrow divisor division, one quotient bit per clock.
// ----------------------------------------------------------------------------
module pas_div
#(
    parameter int DIVISOR_W = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [31:0]           dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [31:0]           quotient
);

    localparam int QW   = 32;
    localparam int CNTW = $clog2(QW);

    logic [QW-1:0]         dvd_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dsr_reg;
    logic [CNTW-1:0]       cnt_reg;
    logic                  run_reg;
    logic                  done_reg;

    logic [DIVISOR_W:0]    rem_sh;
    logic [DIVISOR_W:0]    rem_sub;
    logic                  ge;

    always_comb
    begin
        rem_sh  = {rem_reg, dvd_reg[QW-1]};
        ge      = (rem_sh >= {1'b0, dsr_reg});
        rem_sub = ge ? (rem_sh - {1'b0, dsr_reg}) : rem_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
                dvd_reg <= dividend;
                dsr_reg <= divisor;
                rem_reg <= '0;
            end
            else if (run_reg)
            begin
                rem_reg <= rem_sub[DIVISOR_W-1:0];
                dvd_reg <= {dvd_reg[QW-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(QW - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule
